// File: design/sct_pkg.sv
// Shared types, token codes and character classes for the small C tokenizer.
`default_nettype none
package sct_pkg;

    // Scanner mode: what kind of token is pending.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_DIGIT = 3'd1,
        MODE_ALPHA = 3'd2,
        MODE_REL   = 3'd3,
        MODE_LOG   = 3'd4
    } mode_t;

    // Token kinds.
    localparam logic [4:0] KIND_INT    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_IF     = 5'd2;
    localparam logic [4:0] KIND_ELSE   = 5'd3;
    localparam logic [4:0] KIND_WHILE  = 5'd4;
    localparam logic [4:0] KIND_PLUS   = 5'd5;
    localparam logic [4:0] KIND_MINUS  = 5'd6;
    localparam logic [4:0] KIND_STAR   = 5'd7;
    localparam logic [4:0] KIND_SLASH  = 5'd8;
    localparam logic [4:0] KIND_LPAREN = 5'd9;
    localparam logic [4:0] KIND_RPAREN = 5'd10;
    localparam logic [4:0] KIND_LBRACE = 5'd11;
    localparam logic [4:0] KIND_RBRACE = 5'd12;
    localparam logic [4:0] KIND_ASSIGN = 5'd13;
    localparam logic [4:0] KIND_SEMI   = 5'd14;
    localparam logic [4:0] KIND_EQ     = 5'd15;
    localparam logic [4:0] KIND_NE     = 5'd16;
    localparam logic [4:0] KIND_LT     = 5'd17;
    localparam logic [4:0] KIND_GT     = 5'd18;
    localparam logic [4:0] KIND_LE     = 5'd19;
    localparam logic [4:0] KIND_GE     = 5'd20;
    localparam logic [4:0] KIND_NOT    = 5'd21;
    localparam logic [4:0] KIND_AND    = 5'd22;
    localparam logic [4:0] KIND_OR     = 5'd23;
    localparam logic [4:0] KIND_END    = 5'd24;
    localparam logic [4:0] KIND_ERR    = 5'd25;

    // Character codes.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Keyword prefixes, one byte per character.
    localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
    localparam logic [39:0] KW_ELSE  = 40'h00_656C_7365;
    localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;

    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    // One result beat.
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [30:0] int_value;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [7:0]  lexeme_length;
        logic        last_of_run;
    } token_t;

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    endfunction

    // Kind of a self-contained one-character operator, KIND_INT when it is not one.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_INT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: design/sct_char_if.sv
// Character input channel of the small C tokenizer.
`default_nettype none
interface sct_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface
`default_nettype wire

// File: design/sct_tok_if.sv
// Token output channel of the small C tokenizer.
`default_nettype none
interface sct_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [30:0] int_value;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  lexeme_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output int_value, output start_line,
                    output start_column, output lexeme_length, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input int_value, input start_line,
                    input start_column, input lexeme_length, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

// File: design/small_c_tokenizer_top.sv
// Top level of the small C tokenizer: scanner state, step logic and token queue.
`default_nettype none
// The tokenizer takes one character beat per clock and turns the stream into token
// beats: integers with their saturated decimal value, identifiers, the keywords if, else
// and while, single and double character operators, an error token for an unknown
// character or a lone & or |, and an end token when a beat with end_of_input arrives.
// Each token carries its start line and column (both from 1, saturating) and its length.
// A character beat is handled in the cycle it is accepted: the scanner registers are
// updated and the zero, one or two tokens it causes are written into a four-entry token
// queue, the last of them flagged with last_of_run. The input is ready whenever the queue
// has room for two tokens, so a character is taken every cycle as long as the sink keeps
// draining; the queue empties at one token per cycle, so a run of characters that each
// end one token and start another holds the input back to the sink's pace. After an error
// the scanner ignores characters until end_of_input; the end token returns every
// scanner register to its reset state, ready for the next text.
module small_c_tokenizer_top #(
    parameter int MAX_LEXEME_LEN = 255,
    parameter int POS_BITS       = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    sct_char_if.sink     chars,
    sct_tok_if.source    tokens
);

    // Position counters are as wide as their cap allows; the cap is all ones.
    localparam int PW = (POS_BITS < 16) ? POS_BITS : 16;
    // Length counter saturates at the smaller of MAX_LEXEME_LEN and 255.
    localparam int LEN_CAP = (MAX_LEXEME_LEN < 255) ? MAX_LEXEME_LEN : 255;
    localparam int LW = $clog2(LEN_CAP + 1);
    localparam logic [LW-1:0] LEN_CAP_V = LW'(LEN_CAP);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Scanner state.
    sct_pkg::mode_t mode_reg, mode_next;
    logic [4:0]     pend_kind_reg, pend_kind_next;
    logic [30:0]    accum_reg, accum_next;
    logic [PW-1:0]  tok_line_reg, tok_line_next;
    logic [PW-1:0]  tok_col_reg, tok_col_next;
    logic [LW-1:0]  tok_len_reg, tok_len_next;
    logic [39:0]    prefix_reg, prefix_next;
    logic [PW-1:0]  cur_line_reg, cur_line_next;
    logic [PW-1:0]  cur_col_reg, cur_col_next;
    logic           halted_reg, halted_next;

    // Token queue.
    sct_pkg::token_t q_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;

    logic [7:0] c;
    logic       accept;
    logic       pop;

    // Pending-token flush.
    logic            fl_valid;
    sct_pkg::token_t fl_tok;
    logic [4:0]      alpha_kind;

    // Scanning a character from the idle mode.
    logic            id_emit;
    sct_pkg::token_t id_tok;
    logic            id_start;
    sct_pkg::mode_t  id_mode;
    logic [4:0]      id_kind;
    logic            id_halt;
    logic [4:0]      sk;

    logic [34:0]     accum_wide;
    logic            log_match;
    logic [4:0]      rel_kind;

    // Up to two tokens in order, then packed into result slots.
    logic            a_valid, b_valid;
    sct_pkg::token_t a_tok, b_tok;
    logic            r0_valid, r1_valid;
    sct_pkg::token_t r0_tok, r1_tok;

    logic            do_idle_scan;

    assign c      = chars.char_code;
    assign accept = chars.valid && chars.ready;
    assign pop    = tokens.valid && tokens.ready;

    assign chars.ready = (count_reg <= (QAW+1)'(QDEPTH - 2));

    // Keyword match on the packed identifier prefix.
    always_comb
    begin
        if (prefix_reg == sct_pkg::KW_IF)
            alpha_kind = sct_pkg::KIND_IF;
        else if (prefix_reg == sct_pkg::KW_ELSE)
            alpha_kind = sct_pkg::KIND_ELSE;
        else if (prefix_reg == sct_pkg::KW_WHILE)
            alpha_kind = sct_pkg::KIND_WHILE;
        else
            alpha_kind = sct_pkg::KIND_IDENT;
    end

    // The token that is pending in the current mode, if any.
    always_comb
    begin
        fl_valid              = 1'b1;
        fl_tok                = '0;
        fl_tok.start_line     = 16'(tok_line_reg);
        fl_tok.start_column   = 16'(tok_col_reg);
        fl_tok.lexeme_length  = 8'(tok_len_reg);
        case (mode_reg)
            sct_pkg::MODE_DIGIT:
            begin
                fl_tok.token_kind = sct_pkg::KIND_INT;
                fl_tok.int_value  = accum_reg;
            end
            sct_pkg::MODE_ALPHA:
                fl_tok.token_kind = alpha_kind;
            sct_pkg::MODE_REL:
                fl_tok.token_kind = pend_kind_reg;
            sct_pkg::MODE_LOG:
            begin
                fl_tok.token_kind    = sct_pkg::KIND_ERR;
                fl_tok.lexeme_length = 8'd1;
            end
            default:
                fl_valid = 1'b0;
        endcase
    end

    // Classification of the incoming character as the start of a new token.
    always_comb
    begin
        sk                  = sct_pkg::single_kind(c);
        id_emit             = 1'b0;
        id_start            = 1'b0;
        id_mode             = sct_pkg::MODE_IDLE;
        id_kind             = sct_pkg::KIND_INT;
        id_halt             = 1'b0;
        id_tok              = '0;
        id_tok.start_line   = 16'(cur_line_reg);
        id_tok.start_column = 16'(cur_col_reg);
        id_tok.lexeme_length = 8'd1;
        if (sct_pkg::is_space(c))
        begin
            id_start = 1'b0;
        end
        else if (sct_pkg::is_decimal(c))
        begin
            id_start = 1'b1;
            id_mode  = sct_pkg::MODE_DIGIT;
            id_kind  = sct_pkg::KIND_INT;
        end
        else if (sct_pkg::is_alpha(c))
        begin
            id_start = 1'b1;
            id_mode  = sct_pkg::MODE_ALPHA;
            id_kind  = sct_pkg::KIND_IDENT;
        end
        else if (sk != sct_pkg::KIND_INT)
        begin
            id_emit           = 1'b1;
            id_tok.token_kind = sk;
        end
        else
        begin
            case (c)
                sct_pkg::CH_EQUAL:
                begin
                    id_start = 1'b1;
                    id_mode  = sct_pkg::MODE_REL;
                    id_kind  = sct_pkg::KIND_ASSIGN;
                end
                sct_pkg::CH_LT:
                begin
                    id_start = 1'b1;
                    id_mode  = sct_pkg::MODE_REL;
                    id_kind  = sct_pkg::KIND_LT;
                end
                sct_pkg::CH_GT:
                begin
                    id_start = 1'b1;
                    id_mode  = sct_pkg::MODE_REL;
                    id_kind  = sct_pkg::KIND_GT;
                end
                sct_pkg::CH_BANG:
                begin
                    id_start = 1'b1;
                    id_mode  = sct_pkg::MODE_REL;
                    id_kind  = sct_pkg::KIND_NOT;
                end
                sct_pkg::CH_AMP:
                begin
                    id_start = 1'b1;
                    id_mode  = sct_pkg::MODE_LOG;
                    id_kind  = sct_pkg::KIND_AND;
                end
                sct_pkg::CH_PIPE:
                begin
                    id_start = 1'b1;
                    id_mode  = sct_pkg::MODE_LOG;
                    id_kind  = sct_pkg::KIND_OR;
                end
                default:
                begin
                    id_emit           = 1'b1;
                    id_tok.token_kind = sct_pkg::KIND_ERR;
                    id_halt           = 1'b1;
                end
            endcase
        end
    end

    // Helpers for continuing a token.
    always_comb
    begin
        // accum * 10 + digit, at most 35 bits wide.
        accum_wide = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + 35'(c - sct_pkg::CH_ZERO);
        log_match  = ((c == sct_pkg::CH_AMP) && (pend_kind_reg == sct_pkg::KIND_AND)) ||
                     ((c == sct_pkg::CH_PIPE) && (pend_kind_reg == sct_pkg::KIND_OR));
        if (pend_kind_reg == sct_pkg::KIND_LT)
            rel_kind = sct_pkg::KIND_LE;
        else if (pend_kind_reg == sct_pkg::KIND_GT)
            rel_kind = sct_pkg::KIND_GE;
        else if (pend_kind_reg == sct_pkg::KIND_NOT)
            rel_kind = sct_pkg::KIND_NE;
        else
            rel_kind = sct_pkg::KIND_EQ;
    end

    // One step of the scanner.
    always_comb
    begin
        mode_next      = mode_reg;
        pend_kind_next = pend_kind_reg;
        accum_next     = accum_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        tok_len_next   = tok_len_reg;
        prefix_next    = prefix_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        halted_next    = halted_reg;
        a_valid        = 1'b0;
        a_tok          = fl_tok;
        b_valid        = 1'b0;
        b_tok          = id_tok;
        do_idle_scan   = 1'b0;

        if (chars.end_of_input)
        begin
            // Flush, then the end token, then back to the reset state.
            a_valid            = fl_valid && !halted_reg;
            b_valid            = 1'b1;
            b_tok              = '0;
            b_tok.token_kind   = sct_pkg::KIND_END;
            b_tok.start_line   = 16'(cur_line_reg);
            b_tok.start_column = 16'(cur_col_reg);
            mode_next      = sct_pkg::MODE_IDLE;
            pend_kind_next = '0;
            accum_next     = '0;
            tok_line_next  = PW'(1);
            tok_col_next   = PW'(1);
            tok_len_next   = '0;
            prefix_next    = '0;
            cur_line_next  = PW'(1);
            cur_col_next   = PW'(1);
            halted_next    = 1'b0;
        end
        else
        begin
            if (!halted_reg)
            begin
                case (mode_reg)
                    sct_pkg::MODE_DIGIT:
                    begin
                        if (sct_pkg::is_decimal(c))
                        begin
                            accum_next   = (accum_wide > 35'(sct_pkg::VAL_MAX)) ?
                                           sct_pkg::VAL_MAX : accum_wide[30:0];
                            tok_len_next = (tok_len_reg < LEN_CAP_V) ?
                                           tok_len_reg + LW'(1) : LEN_CAP_V;
                        end
                        else
                        begin
                            a_valid      = 1'b1;
                            do_idle_scan = 1'b1;
                        end
                    end
                    sct_pkg::MODE_ALPHA:
                    begin
                        if (sct_pkg::is_decimal(c) || sct_pkg::is_alpha(c))
                        begin
                            // Prefixes longer than five characters cannot be keywords.
                            if (prefix_reg[39:32] != 8'd0)
                                prefix_next = '1;
                            else
                                prefix_next = {prefix_reg[31:0], c};
                            tok_len_next = (tok_len_reg < LEN_CAP_V) ?
                                           tok_len_reg + LW'(1) : LEN_CAP_V;
                        end
                        else
                        begin
                            a_valid      = 1'b1;
                            do_idle_scan = 1'b1;
                        end
                    end
                    sct_pkg::MODE_REL:
                    begin
                        if (c == sct_pkg::CH_EQUAL)
                        begin
                            a_valid             = 1'b1;
                            a_tok.token_kind    = rel_kind;
                            a_tok.lexeme_length = 8'd2;
                            mode_next           = sct_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            a_valid      = 1'b1;
                            do_idle_scan = 1'b1;
                        end
                    end
                    sct_pkg::MODE_LOG:
                    begin
                        // The character after & or | is consumed either way.
                        a_valid   = 1'b1;
                        mode_next = sct_pkg::MODE_IDLE;
                        if (log_match)
                        begin
                            a_tok.token_kind    = pend_kind_reg;
                            a_tok.lexeme_length = 8'd2;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                        end
                    end
                    default:
                        do_idle_scan = 1'b1;
                endcase

                if (do_idle_scan)
                begin
                    b_valid   = id_emit;
                    mode_next = sct_pkg::MODE_IDLE;
                    if (id_halt)
                        halted_next = 1'b1;
                    if (id_start)
                    begin
                        mode_next      = id_mode;
                        pend_kind_next = id_kind;
                        tok_line_next  = cur_line_reg;
                        tok_col_next   = cur_col_reg;
                        tok_len_next   = LW'(1);
                        accum_next     = 31'(c - sct_pkg::CH_ZERO);
                        prefix_next    = {32'd0, c};
                    end
                end
            end

            if (c == sct_pkg::CH_NEWLINE)
            begin
                cur_line_next = (cur_line_reg != '1) ? cur_line_reg + PW'(1) : cur_line_reg;
                cur_col_next  = PW'(1);
            end
            else
            begin
                cur_col_next = (cur_col_reg != '1) ? cur_col_reg + PW'(1) : cur_col_reg;
            end
        end

        // Pack the results into consecutive slots and flag the last one.
        r0_valid           = a_valid || b_valid;
        r1_valid           = a_valid && b_valid;
        r0_tok             = a_valid ? a_tok : b_tok;
        r0_tok.last_of_run = !r1_valid;
        r1_tok             = b_tok;
        r1_tok.last_of_run = 1'b1;
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + QAW'(r0_valid) + QAW'(r1_valid);
            count_next  = count_next + (QAW+1)'(r0_valid) + (QAW+1)'(r1_valid);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
            count_next  = count_next - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sct_pkg::MODE_IDLE;
            pend_kind_reg <= '0;
            accum_reg     <= '0;
            tok_line_reg  <= PW'(1);
            tok_col_reg   <= PW'(1);
            tok_len_reg   <= '0;
            prefix_reg    <= '0;
            cur_line_reg  <= PW'(1);
            cur_col_reg   <= PW'(1);
            halted_reg    <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                pend_kind_reg <= pend_kind_next;
                accum_reg     <= accum_next;
                tok_line_reg  <= tok_line_next;
                tok_col_reg   <= tok_col_next;
                tok_len_reg   <= tok_len_next;
                prefix_reg    <= prefix_next;
                cur_line_reg  <= cur_line_next;
                cur_col_reg   <= cur_col_next;
                halted_reg    <= halted_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (accept && r0_valid && (wr_ptr_reg == QAW'(i)))
                q_reg[i] <= r0_tok;
            else if (accept && r1_valid && ((wr_ptr_reg + QAW'(1)) == QAW'(i)))
                q_reg[i] <= r1_tok;
        end
    end

    assign tokens.valid         = (count_reg != '0);
    assign tokens.token_kind    = q_reg[rd_ptr_reg].token_kind;
    assign tokens.int_value     = q_reg[rd_ptr_reg].int_value;
    assign tokens.start_line    = q_reg[rd_ptr_reg].start_line;
    assign tokens.start_column  = q_reg[rd_ptr_reg].start_column;
    assign tokens.lexeme_length = q_reg[rd_ptr_reg].lexeme_length;
    assign tokens.last_of_run   = q_reg[rd_ptr_reg].last_of_run;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the small C tokenizer: stimulus, token predictor and checker.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    // The run is stopped by force once the cycle count passes this limit. A correct run,
    // with every gap and stall at its longest, needs only a fraction of it.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned TOTAL_ITEMS  = 1000;
    localparam int          REPORT_MAX   = 10;

    // One row of the directed table. Where typed is set, want is the token this
    // character must give, taken as it stands; otherwise the predictor decides.
    typedef struct {
        logic [7:0] ch;
        bit         eoi;
        bit         typed;
        token_t     want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sct_char_if char_bus();
    sct_tok_if  tok_bus();

    small_c_tokenizer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_bus),
        .tokens (tok_bus)
    );

    // Predictor state: a private copy of everything the scanner remembers.
    mode_t       lex_mode;
    logic [4:0]  lex_pending;
    logic [30:0] lex_value;
    logic [15:0] tok_line_q;
    logic [15:0] tok_col_q;
    logic [7:0]  tok_len_q;
    logic [39:0] kw_prefix;
    logic [15:0] line_pos;
    logic [15:0] col_pos;
    bit          lex_halted;

    token_t      step_tokens[$];      // tokens caused by the character just accepted
    token_t      expected_tokens[$];  // tokens still owed by the block, oldest first
    stim_row_t   stimulus_rows[$];
    logic [7:0]  text_chars[$];

    bit          steady_flow;         // when set, neither side idles or stalls
    int unsigned cycle_count;
    int unsigned bad_tokens;
    int unsigned tokens_seen;
    int unsigned chars_fed;
    int unsigned live_items;          // characters that reached an active scanner
    int unsigned texts_fed;

    string op_words[19] = '{"+", "-", "*", "/", "(", ")", "{", "}", "=", ";",
                            "==", "!=", "<", ">", "<=", ">=", "!", "&&", "||"};
    string kw_words[9]  = '{"if", "else", "while", "whil", "whilex", "iff", "els",
                            "elsewhere", "If"};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d tokens still expected.",
                     cycle_count, expected_tokens.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Token predictor.
    // ------------------------------------------------------------------

    function automatic void lexer_reset();
        lex_mode    = MODE_IDLE;
        lex_pending = KIND_INT;
        lex_value   = '0;
        tok_line_q  = 16'd1;
        tok_col_q   = 16'd1;
        tok_len_q   = 8'd0;
        kw_prefix   = '0;
        line_pos    = 16'd1;
        col_pos     = 16'd1;
        lex_halted  = 1'b0;
    endfunction

    function automatic token_t made_token(logic [4:0] kind, logic [30:0] value,
                                          logic [15:0] line, logic [15:0] col,
                                          logic [7:0] len);
        token_t t;
        t.token_kind    = kind;
        t.int_value     = value;
        t.start_line    = line;
        t.start_column  = col;
        t.lexeme_length = len;
        t.last_of_run   = 1'b1;
        return t;
    endfunction

    function automatic void note_token(logic [4:0] kind, logic [30:0] value,
                                       logic [15:0] line, logic [15:0] col,
                                       logic [7:0] len);
        token_t t;
        t = made_token(kind, value, line, col, len);
        t.last_of_run = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic logic [7:0] bump_len(logic [7:0] v);
        return (v < 8'hFF) ? v + 8'd1 : v;
    endfunction

    function automatic logic [15:0] bump_pos(logic [15:0] v);
        return (v < 16'hFFFF) ? v + 16'd1 : v;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit letter_char(logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic void begin_token(mode_t mode, logic [4:0] kind);
        lex_mode    = mode;
        lex_pending = kind;
        tok_line_q  = line_pos;
        tok_col_q   = col_pos;
        tok_len_q   = 8'd1;
    endfunction

    // Emit whatever token is pending and go back to idle.
    function automatic void flush_pending();
        logic [4:0] kind;
        case (lex_mode)
            MODE_DIGIT: note_token(KIND_INT, lex_value, tok_line_q, tok_col_q, tok_len_q);
            MODE_ALPHA:
            begin
                kind = KIND_IDENT;
                if (kw_prefix == KW_IF)
                    kind = KIND_IF;
                else if (kw_prefix == KW_ELSE)
                    kind = KIND_ELSE;
                else if (kw_prefix == KW_WHILE)
                    kind = KIND_WHILE;
                note_token(kind, '0, tok_line_q, tok_col_q, tok_len_q);
            end
            MODE_REL: note_token(lex_pending, '0, tok_line_q, tok_col_q, tok_len_q);
            MODE_LOG:
            begin
                note_token(KIND_ERR, '0, tok_line_q, tok_col_q, 8'd1);
                lex_halted = 1'b1;
            end
            default: ;
        endcase
        lex_mode = MODE_IDLE;
    endfunction

    // A character seen with nothing pending.
    function automatic void scan_start(logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE)
            return;
        if (digit_char(c))
        begin
            begin_token(MODE_DIGIT, KIND_INT);
            lex_value = 31'(c - CH_ZERO);
            return;
        end
        if (letter_char(c))
        begin
            begin_token(MODE_ALPHA, KIND_IDENT);
            kw_prefix = {32'h0, c};
            return;
        end
        case (c)
            CH_PLUS:   note_token(KIND_PLUS,   '0, line_pos, col_pos, 8'd1);
            CH_MINUS:  note_token(KIND_MINUS,  '0, line_pos, col_pos, 8'd1);
            CH_STAR:   note_token(KIND_STAR,   '0, line_pos, col_pos, 8'd1);
            CH_SLASH:  note_token(KIND_SLASH,  '0, line_pos, col_pos, 8'd1);
            CH_LPAREN: note_token(KIND_LPAREN, '0, line_pos, col_pos, 8'd1);
            CH_RPAREN: note_token(KIND_RPAREN, '0, line_pos, col_pos, 8'd1);
            CH_LBRACE: note_token(KIND_LBRACE, '0, line_pos, col_pos, 8'd1);
            CH_RBRACE: note_token(KIND_RBRACE, '0, line_pos, col_pos, 8'd1);
            CH_SEMI:   note_token(KIND_SEMI,   '0, line_pos, col_pos, 8'd1);
            CH_EQUAL:  begin_token(MODE_REL, KIND_ASSIGN);
            CH_LT:     begin_token(MODE_REL, KIND_LT);
            CH_GT:     begin_token(MODE_REL, KIND_GT);
            CH_BANG:   begin_token(MODE_REL, KIND_NOT);
            CH_AMP:    begin_token(MODE_LOG, KIND_AND);
            CH_PIPE:   begin_token(MODE_LOG, KIND_OR);
            default:
            begin
                note_token(KIND_ERR, '0, line_pos, col_pos, 8'd1);
                lex_halted = 1'b1;
            end
        endcase
    endfunction

    // A character seen while a token may be pending.
    function automatic void scan_next(logic [7:0] c);
        longint unsigned grown;
        logic [4:0]      kind;
        case (lex_mode)
            MODE_DIGIT:
                if (digit_char(c))
                begin
                    grown = longint'(lex_value) * 10 + longint'(c - CH_ZERO);
                    lex_value = (grown > longint'(VAL_MAX)) ? VAL_MAX : 31'(grown);
                    tok_len_q = bump_len(tok_len_q);
                    return;
                end
            MODE_ALPHA:
                if (digit_char(c) || letter_char(c))
                begin
                    // Past five characters the word can no longer be a keyword.
                    if (kw_prefix[39:32] != 8'h00)
                        kw_prefix = '1;
                    else
                        kw_prefix = {kw_prefix[31:0], c};
                    tok_len_q = bump_len(tok_len_q);
                    return;
                end
            MODE_REL:
                if (c == CH_EQUAL)
                begin
                    kind = KIND_EQ;
                    if (lex_pending == KIND_LT)
                        kind = KIND_LE;
                    else if (lex_pending == KIND_GT)
                        kind = KIND_GE;
                    else if (lex_pending == KIND_NOT)
                        kind = KIND_NE;
                    note_token(kind, '0, tok_line_q, tok_col_q, 8'd2);
                    lex_mode = MODE_IDLE;
                    return;
                end
            MODE_LOG:
            begin
                // The second character is consumed either way.
                if ((c == CH_AMP && lex_pending == KIND_AND) ||
                    (c == CH_PIPE && lex_pending == KIND_OR))
                    note_token(lex_pending, '0, tok_line_q, tok_col_q, 8'd2);
                else
                    flush_pending();
                lex_mode = MODE_IDLE;
                return;
            end
            default:
            begin
                scan_start(c);
                return;
            end
        endcase
        flush_pending();
        if (!lex_halted)
            scan_start(c);
    endfunction

    // Work out the tokens one accepted character beat causes.
    function automatic void lexer_step(logic [7:0] c, bit eoi);
        step_tokens.delete();
        if (eoi)
        begin
            if (!lex_halted)
                flush_pending();
            note_token(KIND_END, '0, line_pos, col_pos, 8'd0);
            lexer_reset();
        end
        else
        begin
            if (!lex_halted)
                scan_next(c);
            if (c == CH_NEWLINE)
            begin
                line_pos = bump_pos(line_pos);
                col_pos  = 16'd1;
            end
            else
                col_pos = bump_pos(col_pos);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic void add_row(logic [7:0] ch, bit eoi, bit typed, token_t want);
        stim_row_t r;
        r.ch    = ch;
        r.eoi   = eoi;
        r.typed = typed;
        r.want  = want;
        stimulus_rows.push_back(r);
    endfunction

    function automatic void add_word(string s);
        for (int i = 0; i < s.len(); i++)
            text_chars.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    // Build one random text. Most texts are well-formed token streams with random
    // spacing; tokens that touch each other make a single beat end one token and
    // start the next. A third of the texts also carry stray bytes and lone & or |.
    function automatic void build_text();
        int n_tok;
        int pick;
        int len;
        bit noisy;
        text_chars.delete();
        noisy = ($urandom_range(0, 2) == 0);
        n_tok = $urandom_range(1, 12);
        for (int t = 0; t < n_tok; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12)
                                                   : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    text_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            else if (pick < 40)
                add_word(kw_words[$urandom_range(0, 8)]);
            else if (pick < 55)
            begin
                text_chars.push_back(rand_letter());
                len = $urandom_range(0, 7);
                for (int i = 0; i < len; i++)
                    text_chars.push_back($urandom_range(0, 3) == 0
                                         ? CH_ZERO + 8'($urandom_range(0, 9))
                                         : rand_letter());
            end
            else if (!noisy || pick < 92)
                add_word(op_words[$urandom_range(0, 18)]);
            else if (pick < 96)
                text_chars.push_back($urandom_range(0, 1) ? CH_AMP : CH_PIPE);
            else
                text_chars.push_back(8'($urandom_range(0, 255)));

            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                4, 5, 6: text_chars.push_back(CH_SPACE);
                7:       text_chars.push_back(CH_TAB);
                8:       text_chars.push_back(CH_NEWLINE);
                default:
                begin
                    text_chars.push_back(CH_NEWLINE);
                    text_chars.push_back(CH_SPACE);
                end
            endcase
        end
    endfunction

    // Offer one character beat, wait for the block to take it, then log the tokens
    // it owes. A typed row replaces the predictor's answer by the table's.
    task automatic feed_char(logic [7:0] c, bit eoi, bit typed, token_t want);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            char_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_bus.valid        <= 1'b1;
        char_bus.char_code    <= c;
        char_bus.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!char_bus.ready);
        chars_fed++;
        if (!lex_halted)
            live_items++;
        lexer_step(c, eoi);
        if (typed)
            expected_tokens.push_back(want);
        else
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
    endtask

    // Hold the input back until every owed token has come out.
    task automatic drain_tokens();
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic feed_end();
        feed_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        texts_fed++;
    endtask

    // ------------------------------------------------------------------
    // Token sink and checker.
    // ------------------------------------------------------------------

    initial
    begin
        token_t got;
        token_t want;
        int     stall;
        tok_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                @(negedge clk);
                tok_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            tok_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!tok_bus.valid);
            got.token_kind    = tok_bus.token_kind;
            got.int_value     = tok_bus.int_value;
            got.start_line    = tok_bus.start_line;
            got.start_column  = tok_bus.start_column;
            got.lexeme_length = tok_bus.lexeme_length;
            got.last_of_run   = tok_bus.last_of_run;
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                bad_tokens++;
                if (bad_tokens <= REPORT_MAX)
                    $display("Unexpected token at cycle %0d: kind %0d value %0d pos %0d:%0d len %0d last %0b",
                             cycle_count, got.token_kind, got.int_value, got.start_line,
                             got.start_column, got.lexeme_length, got.last_of_run);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (got !== want)
                begin
                    bad_tokens++;
                    if (bad_tokens <= REPORT_MAX)
                    begin
                        $display("Token mismatch at cycle %0d:", cycle_count);
                        $display("  expected kind %0d value %0d pos %0d:%0d len %0d last %0b",
                                 want.token_kind, want.int_value, want.start_line,
                                 want.start_column, want.lexeme_length, want.last_of_run);
                        $display("  actual   kind %0d value %0d pos %0d:%0d len %0d last %0b",
                                 got.token_kind, got.int_value, got.start_line,
                                 got.start_column, got.lexeme_length, got.last_of_run);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                 = 1'b0;
        char_bus.valid        = 1'b0;
        char_bus.char_code    = 8'h00;
        char_bus.end_of_input = 1'b0;
        steady_flow           = 1'b0;
        lexer_reset();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. The error and end rows are simple enough to state outright:
        // an unknown byte (printable, NUL or above 127) gives an error at its own
        // position and stops the scanner, and the end token sits at the position the
        // column counter has reached, even over ignored characters. A lone | after &
        // is an error at the &, and a pending | at end of input is flushed as an error
        // ahead of the end token. Digit then operator shows two tokens from one beat,
        // and "while" followed by ">=" and "!" covers a keyword and the relational forms.
        add_row("@",        1'b0, 1'b1, made_token(KIND_ERR, '0, 16'd1, 16'd1, 8'd1));
        add_row(8'h5A,      1'b1, 1'b1, made_token(KIND_END, '0, 16'd1, 16'd2, 8'd0));
        add_row(8'hFF,      1'b0, 1'b1, made_token(KIND_ERR, '0, 16'd1, 16'd1, 8'd1));
        add_row(8'h00,      1'b0, 1'b0, '0);
        add_row(8'hA5,      1'b1, 1'b1, made_token(KIND_END, '0, 16'd1, 16'd3, 8'd0));
        add_row(8'h00,      1'b0, 1'b1, made_token(KIND_ERR, '0, 16'd1, 16'd1, 8'd1));
        add_row(8'h00,      1'b1, 1'b1, made_token(KIND_END, '0, 16'd1, 16'd2, 8'd0));
        add_row(CH_AMP,     1'b0, 1'b0, '0);
        add_row(CH_PIPE,    1'b0, 1'b1, made_token(KIND_ERR, '0, 16'd1, 16'd1, 8'd1));
        add_row(8'h00,      1'b1, 1'b1, made_token(KIND_END, '0, 16'd1, 16'd3, 8'd0));
        add_row(CH_PIPE,    1'b0, 1'b0, '0);
        add_row(8'hFF,      1'b1, 1'b0, '0);
        add_row("9",        1'b0, 1'b0, '0);
        add_row(CH_PLUS,    1'b0, 1'b0, '0);
        add_row(CH_NEWLINE, 1'b0, 1'b0, '0);
        add_row("w",        1'b0, 1'b0, '0);
        add_row("h",        1'b0, 1'b0, '0);
        add_row("i",        1'b0, 1'b0, '0);
        add_row("l",        1'b0, 1'b0, '0);
        add_row("e",        1'b0, 1'b0, '0);
        add_row(CH_GT,      1'b0, 1'b0, '0);
        add_row(CH_EQUAL,   1'b0, 1'b0, '0);
        add_row(CH_BANG,    1'b0, 1'b0, '0);
        add_row(CH_TAB,     1'b0, 1'b0, '0);
        add_row(8'h3C,      1'b1, 1'b0, '0);
        foreach (stimulus_rows[i])
            feed_char(stimulus_rows[i].ch, stimulus_rows[i].eoi,
                      stimulus_rows[i].typed, stimulus_rows[i].want);
        texts_fed += 6;
        drain_tokens();

        // Overlong identifier and integer: the length stops at 255 and the value
        // stops at its maximum.
        for (int i = 0; i < 300; i++)
            feed_char("z", 1'b0, 1'b0, '0);
        feed_char(CH_SPACE, 1'b0, 1'b0, '0);
        for (int i = 0; i < 300; i++)
            feed_char("9", 1'b0, 1'b0, '0);
        feed_end();

        // Random texts until the item budget is spent. Some run with no idling on
        // either side; now and then the input waits for the block to run dry before
        // the next text.
        while (chars_fed < TOTAL_ITEMS)
        begin
            build_text();
            steady_flow = ($urandom_range(0, 4) == 0);
            foreach (text_chars[i])
                feed_char(text_chars[i], 1'b0, 1'b0, '0);
            feed_end();
            if ($urandom_range(0, 9) == 0)
                drain_tokens();
        end
        steady_flow = 1'b0;

        @(negedge clk);
        char_bus.valid <= 1'b0;
        drain_tokens();
        // Keep the clock running so that any surplus token still gets caught.
        repeat (20) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            bad_tokens += expected_tokens.size();
            $display("%0d expected tokens never arrived.", expected_tokens.size());
        end

        $display("Fed %0d texts, %0d character beats (%0d to a live scanner), %0d tokens checked.",
                 texts_fed, chars_fed, live_items, tokens_seen);
        $display("Covered errors, keywords, operators, and the length and value ceilings.");
        if (bad_tokens == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

// File: small_c_tokenizer_top.f
design/sct_pkg.sv
design/sct_char_if.sv
design/sct_tok_if.sv
design/small_c_tokenizer_top.sv
bench/tb_top.sv
